// ----- hw/rtl/rsmp_pkg.sv -----
// Shared constants, coefficient table and control types for the 9/20 I/Q resampler.
// Used by rsmp_seq, rsmp_mac and polyphase_resampler_9_20_iq. No dependencies.
package rsmp_pkg;

    localparam int TAPS     = 16;
    localparam int INTERP   = 9;
    localparam int DECIM    = 20;
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 17;
    localparam int GAIN_W   = 16;
    localparam int GAIN_FRAC = 12;
    localparam int COEF_FRAC = 15;
    localparam int OUT_SHIFT = COEF_FRAC + GAIN_FRAC;

    localparam int TAP_W   = $clog2(TAPS);
    localparam int ROW_W   = $clog2(INTERP);
    localparam int PHASE_W = 5;
    localparam int STEP_W  = 5;

    // one 17x17 signed multiplier serves taps and gain halves
    localparam int MUL_W  = 17;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = 33;              // |dot| < 2^32 for every row
    localparam int HALF_W = 16;              // gain multiply splits acc at this bit
    localparam int SCL_W  = ACC_W + GAIN_W + 1;
    localparam int RND_W  = SCL_W - OUT_SHIFT;

    localparam logic [GAIN_W-1:0]  GAIN_RESET = 16'd4096;
    localparam logic [PHASE_W-1:0] PHASE_UP   = PHASE_W'(DECIM - INTERP);
    localparam logic [PHASE_W-1:0] PHASE_DN   = PHASE_W'(INTERP);

    // schedule of one channel pass
    localparam logic [STEP_W-1:0] STEP_ACC_FIRST = STEP_W'(1);
    localparam logic [STEP_W-1:0] STEP_ACC_LAST  = STEP_W'(TAPS);
    localparam logic [STEP_W-1:0] STEP_MUL_HI    = STEP_W'(TAPS + 1);
    localparam logic [STEP_W-1:0] STEP_MUL_LO    = STEP_W'(TAPS + 2);
    localparam logic [STEP_W-1:0] STEP_SUM_LO    = STEP_W'(TAPS + 3);
    localparam logic [STEP_W-1:0] STEP_RESULT    = STEP_W'(TAPS + 4);

    localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

    typedef enum logic [1:0] {
        MUL_TAP     = 2'd0,
        MUL_GAIN_HI = 2'd1,
        MUL_GAIN_LO = 2'd2
    } t_mul_sel;

    typedef struct packed {
        logic [TAP_W-1:0] tap;
        t_mul_sel         mul_sel;
        logic             acc_load;
        logic             acc_add;
        logic             scl_load;
        logic             scl_add;
        logic             res_store;
        logic             res_chan;   // 0: I, 1: Q
    } t_ctrl;

    localparam logic signed [COEF_W-1:0] COEF_ROM [INTERP][TAPS] = '{
        '{-17'sd121, 17'sd576, 17'sd1082, -17'sd1724, -17'sd4744, 17'sd3044,
          17'sd21992, 17'sd32768, 17'sd21992, 17'sd3044, -17'sd4744, -17'sd1724,
          17'sd1082, 17'sd576, -17'sd121, -17'sd56},
        '{-17'sd138, 17'sd457, 17'sd1145, -17'sd1243, -17'sd4742, 17'sd1433,
          17'sd19850, 17'sd32617, 17'sd24025, 17'sd4821, -17'sd4599, -17'sd2219,
          17'sd971, 17'sd696, -17'sd93, -17'sd73},
        '{-17'sd144, 17'sd344, 17'sd1165, -17'sd790, -17'sd4613, 17'sd0,
          17'sd17638, 17'sd32168, 17'sd25916, 17'sd6743, -17'sd4294, -17'sd2716,
          17'sd809, 17'sd814, -17'sd53, -17'sd90},
        '{-17'sd143, 17'sd240, 17'sd1146, -17'sd373, -17'sd4374, -17'sd1244,
          17'sd15390, 17'sd31428, 17'sd27631, 17'sd8789, -17'sd3815, -17'sd3197,
          17'sd593, 17'sd923, 17'sd0, -17'sd108},
        '{-17'sd135, 17'sd147, 17'sd1096, 17'sd0, -17'sd4045, -17'sd2295,
          17'sd13144, 17'sd30412, 17'sd29139, 17'sd10933, -17'sd3150, -17'sd3647,
          17'sd323, 17'sd1019, 17'sd67, -17'sd123},
        '{-17'sd123, 17'sd67, 17'sd1019, 17'sd323, -17'sd3647, -17'sd3150,
          17'sd10933, 17'sd29139, 17'sd30412, 17'sd13144, -17'sd2295, -17'sd4045,
          17'sd0, 17'sd1096, 17'sd147, -17'sd135},
        '{-17'sd108, 17'sd0, 17'sd923, 17'sd593, -17'sd3197, -17'sd3815,
          17'sd8789, 17'sd27631, 17'sd31428, 17'sd15390, -17'sd1244, -17'sd4374,
          -17'sd373, 17'sd1146, 17'sd240, -17'sd143},
        '{-17'sd90, -17'sd53, 17'sd814, 17'sd809, -17'sd2716, -17'sd4294,
          17'sd6743, 17'sd25916, 17'sd32168, 17'sd17638, 17'sd0, -17'sd4613,
          -17'sd790, 17'sd1165, 17'sd344, -17'sd144},
        '{-17'sd73, -17'sd93, 17'sd696, 17'sd971, -17'sd2219, -17'sd4599,
          17'sd4821, 17'sd24025, 17'sd32617, 17'sd19850, 17'sd1433, -17'sd4742,
          -17'sd1243, 17'sd1145, 17'sd457, -17'sd138}
    };

endpackage

// ----- hw/rtl/rsmp_seq.sv -----
// Sequencer for the resampler: steps the shared multiplier through the I and Q passes.
// Depends on rsmp_pkg.
module rsmp_seq
    import rsmp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,     // accepted transaction that produces a result
    input  logic  i_out_free,  // output register can take a new result
    output logic  o_idle,
    output logic  o_load_out,
    output t_ctrl o_ctrl
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CALC = 3'b010,
        S_HOLD = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [STEP_W-1:0]  r_step, n_step;
    logic               r_chan, n_chan;
    logic               w_calc;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_chan  = r_chan;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_CALC;
                    n_step  = '0;
                    n_chan  = 1'b0;
                end
            end
            S_CALC: begin
                if (r_step == STEP_RESULT) begin
                    n_step = '0;
                    if (r_chan) begin
                        n_state = S_HOLD;
                    end else begin
                        n_chan = 1'b1;
                    end
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_HOLD: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_chan  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_chan  <= n_chan;
        end
    end

    assign w_calc     = (r_state == S_CALC);
    assign o_idle     = (r_state == S_IDLE);
    assign o_load_out = (r_state == S_HOLD) && i_out_free;

    always_comb begin
        o_ctrl.tap = r_step[TAP_W-1:0];
        if (r_step == STEP_MUL_HI) begin
            o_ctrl.mul_sel = MUL_GAIN_HI;
        end else if (r_step == STEP_MUL_LO) begin
            o_ctrl.mul_sel = MUL_GAIN_LO;
        end else begin
            o_ctrl.mul_sel = MUL_TAP;
        end
        // products are registered and land in the cycle after issue
        o_ctrl.acc_load  = w_calc && (r_step == STEP_ACC_FIRST);
        o_ctrl.acc_add   = w_calc && (r_step > STEP_ACC_FIRST) && (r_step <= STEP_ACC_LAST);
        o_ctrl.scl_load  = w_calc && (r_step == STEP_MUL_LO);
        o_ctrl.scl_add   = w_calc && (r_step == STEP_SUM_LO);
        o_ctrl.res_store = w_calc && (r_step == STEP_RESULT);
        o_ctrl.res_chan  = r_chan;
    end

endmodule

// ----- hw/rtl/rsmp_mac.sv -----
// Shared 17x17 multiply-accumulate datapath: tap products, gain scaling, rounding, saturation.
// Depends on rsmp_pkg.
module rsmp_mac
    import rsmp_pkg::*;
(
    input  logic                       i_clk,
    input  t_ctrl                      i_ctrl,
    input  logic signed [SAMPLE_W-1:0] i_tap_sample,
    input  logic [ROW_W-1:0]           i_row,
    input  logic [GAIN_W-1:0]          i_gain,
    output logic signed [SAMPLE_W-1:0] o_i_res,
    output logic signed [SAMPLE_W-1:0] o_q_res
);

    logic signed [MUL_W-1:0]    w_op_a, w_op_b;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [SCL_W-1:0]    r_scl;
    logic signed [SCL_W-1:0]    w_biased;
    logic signed [RND_W-1:0]    w_shifted;
    logic signed [SAMPLE_W-1:0] w_sat;
    logic signed [SAMPLE_W-1:0] r_i_res, r_q_res;

    always_comb begin
        case (i_ctrl.mul_sel)
            MUL_TAP: begin
                w_op_a = MUL_W'(i_tap_sample);
                w_op_b = COEF_ROM[i_row][i_ctrl.tap];
            end
            MUL_GAIN_HI: begin
                w_op_a = r_acc[ACC_W-1:HALF_W];
                w_op_b = $signed({1'b0, i_gain});
            end
            MUL_GAIN_LO: begin
                w_op_a = $signed({1'b0, r_acc[HALF_W-1:0]});
                w_op_b = $signed({1'b0, i_gain});
            end
            default: begin
                w_op_a = '0;
                w_op_b = '0;
            end
        endcase
    end

    // scaled = (acc_hi * gain) << 16 + acc_lo * gain, then round half up by 2^27
    assign w_biased  = r_scl + (SCL_W'(1) <<< (OUT_SHIFT - 1));
    assign w_shifted = w_biased[SCL_W-1:OUT_SHIFT];

    always_comb begin
        if (w_shifted > RND_W'(SAT_MAX)) begin
            w_sat = SAT_MAX;
        end else if (w_shifted < RND_W'(SAT_MIN)) begin
            w_sat = SAT_MIN;
        end else begin
            w_sat = w_shifted[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_op_a * w_op_b;
        if (i_ctrl.acc_load) begin
            r_acc <= r_prod[ACC_W-1:0];
        end else if (i_ctrl.acc_add) begin
            r_acc <= r_acc + r_prod[ACC_W-1:0];
        end
        if (i_ctrl.scl_load) begin
            r_scl <= {r_prod[SCL_W-HALF_W-1:0], {HALF_W{1'b0}}};
        end else if (i_ctrl.scl_add) begin
            r_scl <= r_scl + SCL_W'(r_prod);
        end
        if (i_ctrl.res_store) begin
            if (i_ctrl.res_chan) begin
                r_q_res <= w_sat;
            end else begin
                r_i_res <= w_sat;
            end
        end
    end

    assign o_i_res = r_i_res;
    assign o_q_res = r_q_res;

endmodule

// ----- hw/rtl/polyphase_resampler_9_20_iq.sv -----
// Top level of the 9/20 polyphase I/Q resampler: handshakes, histories, phase, gain register.
// Depends on rsmp_pkg, rsmp_seq and rsmp_mac.
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  input    | i_in_valid, o_in_ready, i_i_sample, i_q_sample | in
//  output   | o_out_valid, i_out_ready, o_i_result, o_q_result | out
//  config   | i_cfg_valid, o_cfg_ready, i_cfg_data (output_gain) | in
//
// Every input shifts the histories and steps the phase. An input that yields an output also
// holds o_in_ready low until its result is in the output register: one 17x17 multiplier
// runs 21 steps per channel (16 taps, two gain halves, sum, round/saturate) for I, then for Q.
// Reset is synchronous, active low; it clears histories and phase and sets the gain to unity.
// The output register holds a result while the next input is taken; a finished result
// waits in the datapath until the output register frees.
module polyphase_resampler_9_20_iq
    import rsmp_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic signed [SAMPLE_W-1:0] i_i_sample,
    input  logic signed [SAMPLE_W-1:0] i_q_sample,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [SAMPLE_W-1:0] o_i_result,
    output logic signed [SAMPLE_W-1:0] o_q_result,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [GAIN_W-1:0]          i_cfg_data
);

    logic signed [SAMPLE_W-1:0] r_hist_i [TAPS];
    logic signed [SAMPLE_W-1:0] r_hist_q [TAPS];
    logic [PHASE_W-1:0]         r_phase;
    logic [ROW_W-1:0]           r_row;
    logic [GAIN_W-1:0]          r_gain;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_i_result, r_q_result;

    logic                       w_accept, w_emit, w_idle, w_load_out, w_out_free;
    t_ctrl                      w_ctrl;
    logic signed [SAMPLE_W-1:0] w_tap_sample, w_i_res, w_q_res;

    assign o_in_ready  = w_idle;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && w_idle;
    assign w_emit      = (r_phase < PHASE_W'(INTERP));
    assign w_out_free  = !r_out_valid || i_out_ready;

    // oldest sample at index 0, newest at TAPS-1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TAPS; k++) begin
                r_hist_i[k] <= '0;
                r_hist_q[k] <= '0;
            end
            r_phase <= '0;
        end else if (w_accept) begin
            for (int k = 0; k < TAPS - 1; k++) begin
                r_hist_i[k] <= r_hist_i[k+1];
                r_hist_q[k] <= r_hist_q[k+1];
            end
            r_hist_i[TAPS-1] <= i_i_sample;
            r_hist_q[TAPS-1] <= i_q_sample;
            r_phase <= w_emit ? r_phase + PHASE_UP : r_phase - PHASE_DN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_row <= r_phase[ROW_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
        end else if (i_cfg_valid) begin
            r_gain <= i_cfg_data;
        end
    end

    assign w_tap_sample = w_ctrl.res_chan ? r_hist_q[w_ctrl.tap] : r_hist_i[w_ctrl.tap];

    rsmp_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept && w_emit),
        .i_out_free (w_out_free),
        .o_idle     (w_idle),
        .o_load_out (w_load_out),
        .o_ctrl     (w_ctrl)
    );

    rsmp_mac u_mac (
        .i_clk        (i_clk),
        .i_ctrl       (w_ctrl),
        .i_tap_sample (w_tap_sample),
        .i_row        (r_row),
        .i_gain       (r_gain),
        .o_i_res      (w_i_res),
        .o_q_res      (w_q_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_i_result <= w_i_res;
            r_q_result <= w_q_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_i_result  = r_i_result;
    assign o_q_result  = r_q_result;

endmodule
